// ===== src/cfq_pkg.sv =====
// ----------------------------------------------------------------------------
// Circular FIFO queue package
// Types, codes and field widths shared by the queue's controller, datapath
// and top level.
// ----------------------------------------------------------------------------
package cfq_pkg;

  localparam int ITEM_W    = 32;
  localparam int CAP_W     = 5;
  localparam int FUNC_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int M_TDATA_W = 72;

  localparam logic [0:0] REG_CAPACITY = 1'b0;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_QUERY = 2'd2
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

// ===== src/circular_fifo_queue_top.sv =====
// An accepted word updates the pointers and count; the entry store is then
// read into its registered read data, and the result is loaded into the
// output register once that register is free. A new word is not taken before
// the last result is loaded. The finished result waits in an output register,
// so the next word is taken while it is still pending. Reset is asynchronous,
// clears pointers, count and output valid and sets capacity to DEPTH (max 31).
// ----------------------------------------------------------------------------
// Circular FIFO queue top level
// Bounded circular queue with push, pop and query words and a configurable
// capacity register.
// ----------------------------------------------------------------------------
module circular_fifo_queue_top #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cfq_pkg::APB_AW-1:0]        paddr,
  input  logic [cfq_pkg::APB_DW-1:0]        pwdata,
  output logic [cfq_pkg::APB_DW-1:0]        prdata,
  output logic                              pready,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // item_value[31:0]
  input  logic [cfq_pkg::ITEM_W-1:0]        s_axis_tdata,
  // func[1:0]
  input  logic [cfq_pkg::FUNC_W-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // front_value[31:0], back_value[63:32], entry_count[68:64], is_empty[69],
  // is_full[70], zero[71]
  output logic [cfq_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // status[1:0]
  output logic [cfq_pkg::STATUS_W-1:0]      m_axis_tuser
);

  cfq_pkg::ctrl_cmd_t        cmd;
  cfq_pkg::dp_stat_t         stat;
  logic                      cfg_we;
  logic [cfq_pkg::CAP_W-1:0] cap;
  logic                      reg_hit;

  assign reg_hit = (paddr[cfq_pkg::APB_AW-1:2] == cfq_pkg::REG_CAPACITY);
  assign cfg_we  = psel && penable && pwrite && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? cfq_pkg::APB_DW'(cap) : '0;

  cfq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  cfq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (pwdata[cfq_pkg::CAP_W-1:0]),
    .cap_o        (cap),
    .func_i       (s_axis_tuser),
    .item_value_i (s_axis_tdata),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_o     (m_axis_tdata),
    .m_user_o     (m_axis_tuser)
  );

endmodule

// ===== src/cfq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module cfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== src/cfq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Circular FIFO queue controller
// Sequences one word through update, store read and result load.
// ----------------------------------------------------------------------------
module cfq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  input  cfq_pkg::dp_stat_t    stat_i,
  output cfq_pkg::ctrl_cmd_t   cmd_o
);

  cfq_pkg::state_e state_q;
  cfq_pkg::state_e state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      cfq_pkg::ST_IDLE: begin
        if (s_valid_i) begin
          state_d = cfq_pkg::ST_READ;
        end
      end
      cfq_pkg::ST_READ: begin
        state_d = cfq_pkg::ST_LOAD;
      end
      cfq_pkg::ST_LOAD: begin
        if (stat_i.out_free) begin
          state_d = cfq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cfq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_ready_o    = 1'b0;
    cmd_o.accept = 1'b0;
    cmd_o.rd_en  = 1'b0;
    cmd_o.load   = 1'b0;
    case (state_q)
      cfq_pkg::ST_IDLE: begin
        s_ready_o    = 1'b1;
        cmd_o.accept = s_valid_i;
      end
      cfq_pkg::ST_READ: begin
        cmd_o.rd_en = 1'b1;
      end
      cfq_pkg::ST_LOAD: begin
        cmd_o.load = stat_i.out_free;
      end
      default: begin
        s_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A word is only taken when no other word is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> !s_ready_o ##1 !s_ready_o)
    else $error("cfq_ctrl: word accepted while another was in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |=> (state_q == cfq_pkg::ST_LOAD))
    else $error("cfq_ctrl: store read not followed by result load");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.accept, cmd_o.rd_en, cmd_o.load}))
    else $error("cfq_ctrl: overlapping datapath commands");

endmodule

// ===== src/cfq_datapath.sv =====
// ----------------------------------------------------------------------------
// Circular FIFO queue datapath
// Pointers, count, capacity register, entry store and output register.
// ----------------------------------------------------------------------------
module cfq_datapath #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cfq_pkg::ctrl_cmd_t                cmd_i,
  output cfq_pkg::dp_stat_t                 stat_o,
  input  logic                              cfg_we_i,
  input  logic [cfq_pkg::CAP_W-1:0]         cfg_wdata_i,
  output logic [cfq_pkg::CAP_W-1:0]         cap_o,
  input  logic [cfq_pkg::FUNC_W-1:0]        func_i,
  input  logic [cfq_pkg::ITEM_W-1:0]        item_value_i,
  output logic                              m_valid_o,
  input  logic                              m_ready_i,
  output logic [cfq_pkg::M_TDATA_W-1:0]     m_data_o,
  output logic [cfq_pkg::STATUS_W-1:0]      m_user_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CAP_W = cfq_pkg::CAP_W;
  localparam int CMP_W = (PTR_W + 1 > CAP_W) ? PTR_W + 1 : CAP_W;
  localparam int CAP_MAX = (1 << CAP_W) - 1;
  localparam int CAP_RESET = (DEPTH > CAP_MAX) ? CAP_MAX : DEPTH;
  localparam int PAD_W = cfq_pkg::M_TDATA_W - 2 * cfq_pkg::ITEM_W - CAP_W - 2;

  logic [CAP_W-1:0]             cap_q, cap_d;
  logic [PTR_W-1:0]             rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]             wr_ptr_q, wr_ptr_d;
  logic [CAP_W-1:0]             cnt_q, cnt_d;
  cfq_pkg::status_e             status_q, status_d;
  logic                         m_valid_q;
  logic [cfq_pkg::M_TDATA_W-1:0] m_data_q;
  logic [cfq_pkg::STATUS_W-1:0] m_user_q;

  logic [CAP_W-1:0]             eff_cap;
  logic [PTR_W-1:0]             last_ptr;
  logic                         ram_we;
  logic [DATA_WIDTH-1:0]        front_raw;
  logic [DATA_WIDTH-1:0]        back_raw;
  logic [cfq_pkg::ITEM_W-1:0]   front_val;
  logic [cfq_pkg::ITEM_W-1:0]   back_val;
  logic                         empty;
  logic                         full;
  cfq_pkg::func_e               func;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [CAP_W-1:0] cap);
    logic [CMP_W-1:0] n;
    n = CMP_W'(p) + CMP_W'(1);
    return (n >= CMP_W'(cap)) ? '0 : PTR_W'(n);
  endfunction

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CAP_W'(1);
    end else if (int'(cap_q) > DEPTH) begin
      eff_cap = CAP_W'(DEPTH);
    end else begin
      eff_cap = cap_q;
    end
  end

  assign func = cfq_pkg::func_e'(func_i);

  always_comb begin
    cap_d    = cap_q;
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    cnt_d    = cnt_q;
    status_d = status_q;
    ram_we   = 1'b0;
    if (cfg_we_i) begin
      cap_d    = cfg_wdata_i;
      rd_ptr_d = '0;
      wr_ptr_d = '0;
      cnt_d    = '0;
    end else if (cmd_i.accept) begin
      status_d = cfq_pkg::STATUS_OK;
      case (func)
        cfq_pkg::FUNC_PUSH: begin
          if (cnt_q >= eff_cap) begin
            status_d = cfq_pkg::STATUS_OVERFLOW;
          end else begin
            ram_we   = 1'b1;
            wr_ptr_d = advance(wr_ptr_q, eff_cap);
            cnt_d    = cnt_q + CAP_W'(1);
          end
        end
        cfq_pkg::FUNC_POP: begin
          if (cnt_q == '0) begin
            status_d = cfq_pkg::STATUS_UNDERFLOW;
          end else begin
            rd_ptr_d = advance(rd_ptr_q, eff_cap);
            cnt_d    = cnt_q - CAP_W'(1);
          end
        end
        default: begin
          status_d = cfq_pkg::STATUS_OK;
        end
      endcase
    end
  end

  assign last_ptr = (wr_ptr_q == '0) ? PTR_W'(eff_cap - CAP_W'(1))
                                     : wr_ptr_q - PTR_W'(1);

  cfq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (wr_ptr_q),
    .wdata_i   (DATA_WIDTH'(item_value_i)),
    .re_i      (cmd_i.rd_en),
    .raddr_a_i (rd_ptr_q),
    .raddr_b_i (last_ptr),
    .rdata_a_o (front_raw),
    .rdata_b_o (back_raw)
  );

  assign empty     = (cnt_q == '0);
  assign full      = (cnt_q == eff_cap);
  assign front_val = empty ? '0 : cfq_pkg::ITEM_W'(front_raw);
  assign back_val  = empty ? '0 : cfq_pkg::ITEM_W'(back_raw);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= CAP_W'(CAP_RESET);
      rd_ptr_q  <= '0;
      wr_ptr_q  <= '0;
      cnt_q     <= '0;
      status_q  <= cfq_pkg::STATUS_OK;
      m_valid_q <= 1'b0;
    end else begin
      cap_q    <= cap_d;
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
      status_q <= status_d;
      if (cmd_i.load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_data_q <= {{PAD_W{1'b0}}, full, empty, cnt_q, back_val, front_val};
      m_user_q <= status_q;
    end
  end

  assign stat_o.out_free = !m_valid_q || m_ready_i;
  assign cap_o           = cap_q;
  assign m_valid_o       = m_valid_q;
  assign m_data_o        = m_data_q;
  assign m_user_o        = m_user_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= eff_cap)
    else $error("cfq_datapath: entry count above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (rd_ptr_q == wr_ptr_q))
    else $error("cfq_datapath: pointers differ on an empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CAP_W'(rd_ptr_q) < eff_cap) && (CAP_W'(wr_ptr_q) < eff_cap))
    else $error("cfq_datapath: pointer outside configured capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && !cfg_we_i && func == cfq_pkg::FUNC_PUSH && full)
      |=> (status_q == cfq_pkg::STATUS_OVERFLOW) && $stable(cnt_q))
    else $error("cfq_datapath: push on full queue not flagged");

endmodule
